### rtl/sla_pkg.sv
// Shared types and constants for the signed long integer ALU.
`timescale 1ns / 1ps
`default_nettype none
package sla_pkg;

   localparam int LIMB_W            = 12;
   localparam int DEFAULT_MAX_LIMBS = 32;

   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 4;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 2;

   // Action codes as they arrive on the request channel
   localparam logic [2:0] ACT_APPEND_A = 3'd0;
   localparam logic [2:0] ACT_APPEND_B = 3'd1;
   localparam logic [2:0] ACT_ADD      = 3'd2;
   localparam logic [2:0] ACT_SUB      = 3'd3;
   localparam logic [2:0] ACT_MUL      = 3'd4;

   typedef enum logic [2:0] {
      CMD_APPEND_A = 3'd0,
      CMD_APPEND_B = 3'd1,
      CMD_ADD      = 3'd2,
      CMD_SUB      = 3'd3,
      CMD_MUL      = 3'd4
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic [LIMB_W-1:0]   limb;
      logic                negative;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/sla_front.sv
// Front end: accept request beats, classify them and queue the commands.
`timescale 1ns / 1ps
`default_nettype none
module sla_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [2:0]                 action,
   input  wire logic [sla_pkg::LIMB_W-1:0] limb_value,
   input  wire logic                       operand_negative,
   output logic                            q_valid,
   output sla_pkg::cmd_type                q_cmd,
   input  wire logic                       q_pop
);

   sla_pkg::cmd_type slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             known;
   logic             push;
   sla_pkg::cmd_type cmd;

   // Decode the action; unused codes are taken and dropped
   always_comb begin
      known    = 1'b1;
      cmd.kind = sla_pkg::CMD_APPEND_A;
      unique case (action)
         sla_pkg::ACT_APPEND_A: cmd.kind = sla_pkg::CMD_APPEND_A;
         sla_pkg::ACT_APPEND_B: cmd.kind = sla_pkg::CMD_APPEND_B;
         sla_pkg::ACT_ADD:      cmd.kind = sla_pkg::CMD_ADD;
         sla_pkg::ACT_SUB:      cmd.kind = sla_pkg::CMD_SUB;
         sla_pkg::ACT_MUL:      cmd.kind = sla_pkg::CMD_MUL;
         default:               known    = 1'b0;
      endcase
      cmd.limb     = limb_value;
      cmd.negative = operand_negative;
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready && known;
   assign q_valid    = (count_ff != 2'd0);
   assign q_cmd      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= cmd;
      end
   end

endmodule
`default_nettype wire

### rtl/sla_back.sv
// Back end: operand stores, limb walks, product columns and result emission.
`timescale 1ns / 1ps
`default_nettype none
module sla_back #(
   parameter int MAX_LIMBS = sla_pkg::DEFAULT_MAX_LIMBS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            q_valid,
   input  wire sla_pkg::cmd_type                q_cmd,
   output logic                                 q_pop,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [sla_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   output logic [sla_pkg::RSP_TUSER_W-1:0]      rsp_tuser,
   output logic                                 rsp_tlast
);

   localparam int LW   = $clog2(MAX_LIMBS);
   localparam int LENW = $clog2(MAX_LIMBS + 1);
   localparam int DW   = sla_pkg::LIMB_W;
   localparam int PW   = 2 * DW + LW;
   localparam int CW   = PW + 1 - DW;
   localparam logic [LENW-1:0] MAX_LEN  = LENW'(MAX_LIMBS);
   localparam logic [LENW+1:0] MAX_WIDE = (LENW + 2)'(MAX_LIMBS);

   typedef enum logic [13:0] {
      ST_IDLE    = 14'b00000000000001,
      ST_CMP_RD  = 14'b00000000000010,
      ST_CMP_EV  = 14'b00000000000100,
      ST_ADD_RD  = 14'b00000000001000,
      ST_ADD_EV  = 14'b00000000010000,
      ST_ADD_CRY = 14'b00000000100000,
      ST_CLR     = 14'b00000001000000,
      ST_MUL_RD  = 14'b00000010000000,
      ST_MUL_MUL = 14'b00000100000000,
      ST_MUL_WR  = 14'b00001000000000,
      ST_CRY_RD  = 14'b00010000000000,
      ST_CRY_EV  = 14'b00100000000000,
      ST_EM_RD   = 14'b01000000000000,
      ST_EM_WT   = 14'b10000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [LENW-1:0]     a_len_ff, a_len_in, a_trim_ff, a_trim_in;
   logic [LENW-1:0]     b_len_ff, b_len_in, b_trim_ff, b_trim_in;
   logic                a_sign_ff, a_sign_in, b_sign_ff, b_sign_in;
   logic [LW-1:0]       idx_ff, idx_in, jdx_ff, jdx_in;
   logic [LENW-1:0]     xlen_ff, xlen_in, ylen_ff, ylen_in, walk_ff, walk_in;
   logic [LENW-1:0]     rtrim_ff, rtrim_in;
   logic [CW-1:0]       carry_ff, carry_in;
   logic                sign_ff, sign_in, ovf_ff, ovf_in, sub_ff, sub_in;
   logic                swap_ff, swap_in;
   logic [2*DW-1:0]     prod_ff, prod_in;

   logic [DW-1:0]       a_mem [MAX_LIMBS];
   logic [DW-1:0]       b_mem [MAX_LIMBS];
   logic [PW-1:0]       p_mem [MAX_LIMBS];
   logic [DW-1:0]       r_mem [MAX_LIMBS];
   logic [DW-1:0]       a_q_ff, b_q_ff, r_q_ff;
   logic [PW-1:0]       p_q_ff;

   logic                a_we, b_we, p_we, r_we;
   logic [LW-1:0]       ab_waddr, p_waddr, b_raddr, p_raddr;
   logic [PW-1:0]       p_wdata;
   logic [DW-1:0]       r_wdata;

   logic                rsp_valid_ff, rsp_last_ff, rsp_neg_ff, rsp_ovf_ff;
   logic [DW-1:0]       rsp_limb_ff;
   logic                out_load, out_last;

   logic [LENW-1:0]     idx_len, idx_next_len, jdx_next_len, an, bn, max_len, min_len;
   logic                bs_eff, a_zero, b_zero;
   logic [LENW+1:0]     mul_need;
   logic [DW-1:0]       xd, yd;
   logic [DW:0]         walk_res;
   logic [PW:0]         col_sum;

   assign idx_len      = LENW'(idx_ff);
   assign idx_next_len = idx_len + LENW'(1);
   assign jdx_next_len = LENW'(jdx_ff) + LENW'(1);
   assign an           = a_trim_ff;
   assign bn           = b_trim_ff;
   assign a_zero       = (an == '0);
   assign b_zero       = (bn == '0);
   assign bs_eff       = b_sign_ff ^ (q_cmd.kind == sla_pkg::CMD_SUB);
   assign max_len      = (an > bn) ? an : bn;
   assign min_len      = (an > bn) ? bn : an;
   assign mul_need     = (LENW + 2)'(an) + (LENW + 2)'(bn) + (LENW + 2)'(2);

   assign q_pop = q_valid && (state_ff == ST_IDLE);

   // One limb of the add or subtract walk; limbs past an operand's length read as zero
   always_comb begin
      xd = swap_ff ? b_q_ff : a_q_ff;
      yd = swap_ff ? a_q_ff : b_q_ff;
      if (idx_len >= xlen_ff) xd = '0;
      if (idx_len >= ylen_ff) yd = '0;
      if (sub_ff) begin
         walk_res = {1'b0, xd} - {1'b0, yd} - (DW + 1)'(carry_ff[0]);
      end else begin
         walk_res = {1'b0, xd} + {1'b0, yd} + (DW + 1)'(carry_ff[0]);
      end
      col_sum = {1'b0, p_q_ff} + (PW + 1)'(carry_ff);
   end

   assign out_load = (state_ff == ST_EM_WT) && (!rsp_valid_ff || rsp_tready);
   assign out_last = ovf_ff || (rtrim_ff == '0) || (idx_next_len == rtrim_ff);

   assign b_raddr = (state_ff == ST_MUL_RD) ? jdx_ff : idx_ff;
   assign p_raddr = (state_ff == ST_CRY_RD) ? idx_ff : idx_ff + jdx_ff;

   always_comb begin
      state_in  = state_ff;
      a_len_in  = a_len_ff;  a_trim_in = a_trim_ff;  a_sign_in = a_sign_ff;
      b_len_in  = b_len_ff;  b_trim_in = b_trim_ff;  b_sign_in = b_sign_ff;
      idx_in    = idx_ff;    jdx_in    = jdx_ff;
      xlen_in   = xlen_ff;   ylen_in   = ylen_ff;    walk_in   = walk_ff;
      rtrim_in  = rtrim_ff;  carry_in  = carry_ff;
      sign_in   = sign_ff;   ovf_in    = ovf_ff;     sub_in    = sub_ff;
      swap_in   = swap_ff;   prod_in   = prod_ff;
      a_we      = 1'b0;      b_we      = 1'b0;
      ab_waddr  = a_len_ff[LW-1:0];
      p_we      = 1'b0;      p_waddr   = idx_ff;     p_wdata   = '0;
      r_we      = 1'b0;      r_wdata   = walk_res[DW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               case (q_cmd.kind)
                  sla_pkg::CMD_APPEND_A: begin
                     ab_waddr = a_len_ff[LW-1:0];
                     if (a_len_ff != MAX_LEN) begin
                        a_we      = 1'b1;
                        a_len_in  = a_len_ff + LENW'(1);
                        a_sign_in = q_cmd.negative;
                        if (q_cmd.limb != '0) a_trim_in = a_len_ff + LENW'(1);
                     end
                  end
                  sla_pkg::CMD_APPEND_B: begin
                     ab_waddr = b_len_ff[LW-1:0];
                     if (b_len_ff != MAX_LEN) begin
                        b_we      = 1'b1;
                        b_len_in  = b_len_ff + LENW'(1);
                        b_sign_in = q_cmd.negative;
                        if (q_cmd.limb != '0) b_trim_in = b_len_ff + LENW'(1);
                     end
                  end
                  default: begin
                     // Operation: latch lengths, clear the operands, pick the path
                     a_len_in = '0;  a_trim_in = '0;  a_sign_in = 1'b0;
                     b_len_in = '0;  b_trim_in = '0;  b_sign_in = 1'b0;
                     ovf_in   = 1'b0;
                     rtrim_in = '0;
                     carry_in = '0;
                     idx_in   = '0;
                     jdx_in   = '0;
                     swap_in  = 1'b0;
                     sub_in   = 1'b0;
                     xlen_in  = an;
                     ylen_in  = bn;
                     if (q_cmd.kind == sla_pkg::CMD_MUL) begin
                        sign_in = a_sign_ff ^ b_sign_ff;
                        walk_in = an + bn;
                        if (a_zero || b_zero) begin
                           state_in = ST_EM_RD;
                        end else if (mul_need > MAX_WIDE) begin
                           ovf_in   = 1'b1;
                           state_in = ST_EM_RD;
                        end else begin
                           state_in = ST_CLR;
                        end
                     end else if (a_zero || b_zero || (a_sign_ff == bs_eff)) begin
                        sign_in = a_zero ? bs_eff : a_sign_ff;
                        walk_in = max_len;
                        if (!a_zero && !b_zero && (an == MAX_LEN || bn == MAX_LEN)) begin
                           ovf_in   = 1'b1;
                           state_in = ST_EM_RD;
                        end else if (a_zero && b_zero) begin
                           state_in = ST_EM_RD;
                        end else begin
                           state_in = ST_ADD_RD;
                        end
                     end else begin
                        sub_in  = 1'b1;
                        sign_in = a_sign_ff;
                        walk_in = max_len;
                        if (an != bn) begin
                           swap_in  = (bn > an);
                           sign_in  = (bn > an) ? bs_eff : a_sign_ff;
                           xlen_in  = max_len;
                           ylen_in  = min_len;
                           state_in = ST_ADD_RD;
                        end else begin
                           idx_in   = LW'(an - LENW'(1));
                           state_in = ST_CMP_RD;
                        end
                     end
                  end
               endcase
            end
         end
         ST_CMP_RD: state_in = ST_CMP_EV;
         ST_CMP_EV: begin
            // Scan equal-length magnitudes from the top limb down
            if (a_q_ff != b_q_ff) begin
               if (b_q_ff > a_q_ff) begin
                  swap_in = 1'b1;
                  sign_in = ~sign_ff;
               end
               idx_in   = '0;
               state_in = ST_ADD_RD;
            end else if (idx_ff == '0) begin
               state_in = ST_EM_RD;
            end else begin
               idx_in   = idx_ff - LW'(1);
               state_in = ST_CMP_RD;
            end
         end
         ST_ADD_RD: state_in = ST_ADD_EV;
         ST_ADD_EV: begin
            r_we     = 1'b1;
            carry_in = CW'(walk_res[DW]);
            if (walk_res[DW-1:0] != '0) rtrim_in = idx_next_len;
            idx_in   = idx_ff + LW'(1);
            if (idx_next_len == walk_ff) begin
               if (sub_ff) begin
                  idx_in   = '0;
                  state_in = ST_EM_RD;
               end else begin
                  state_in = ST_ADD_CRY;
               end
            end else begin
               state_in = ST_ADD_RD;
            end
         end
         ST_ADD_CRY: begin
            // Final carry limb; only possible when both operands are short
            r_wdata = DW'(1);
            if (carry_ff[0]) begin
               r_we     = 1'b1;
               rtrim_in = idx_next_len;
            end
            idx_in   = '0;
            state_in = ST_EM_RD;
         end
         ST_CLR: begin
            p_we    = 1'b1;
            p_waddr = idx_ff;
            p_wdata = '0;
            if (idx_next_len == walk_ff) begin
               idx_in   = '0;
               state_in = ST_MUL_RD;
            end else begin
               idx_in = idx_ff + LW'(1);
            end
         end
         ST_MUL_RD: state_in = ST_MUL_MUL;
         ST_MUL_MUL: begin
            prod_in  = a_q_ff * b_q_ff;
            state_in = ST_MUL_WR;
         end
         ST_MUL_WR: begin
            p_we     = 1'b1;
            p_waddr  = idx_ff + jdx_ff;
            p_wdata  = p_q_ff + PW'(prod_ff);
            state_in = ST_MUL_RD;
            if (jdx_next_len == ylen_ff) begin
               jdx_in = '0;
               if (idx_next_len == xlen_ff) begin
                  idx_in   = '0;
                  carry_in = '0;
                  state_in = ST_CRY_RD;
               end else begin
                  idx_in = idx_ff + LW'(1);
               end
            end else begin
               jdx_in = jdx_ff + LW'(1);
            end
         end
         ST_CRY_RD: state_in = ST_CRY_EV;
         ST_CRY_EV: begin
            // Fold the column carries into 12-bit limbs
            r_we     = 1'b1;
            r_wdata  = col_sum[DW-1:0];
            carry_in = col_sum[PW:DW];
            if (col_sum[DW-1:0] != '0) rtrim_in = idx_next_len;
            if (idx_next_len == walk_ff) begin
               idx_in   = '0;
               state_in = ST_EM_RD;
            end else begin
               idx_in   = idx_ff + LW'(1);
               state_in = ST_CRY_RD;
            end
         end
         ST_EM_RD: state_in = ST_EM_WT;
         ST_EM_WT: begin
            if (out_load) begin
               if (out_last) begin
                  idx_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + LW'(1);
                  state_in = ST_EM_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         a_len_ff     <= '0;
         a_trim_ff    <= '0;
         a_sign_ff    <= 1'b0;
         b_len_ff     <= '0;
         b_trim_ff    <= '0;
         b_sign_ff    <= 1'b0;
         idx_ff       <= '0;
         jdx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         a_len_ff  <= a_len_in;
         a_trim_ff <= a_trim_in;
         a_sign_ff <= a_sign_in;
         b_len_ff  <= b_len_in;
         b_trim_ff <= b_trim_in;
         b_sign_ff <= b_sign_in;
         idx_ff    <= idx_in;
         jdx_ff    <= jdx_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      xlen_ff  <= xlen_in;
      ylen_ff  <= ylen_in;
      walk_ff  <= walk_in;
      rtrim_ff <= rtrim_in;
      carry_ff <= carry_in;
      sign_ff  <= sign_in;
      ovf_ff   <= ovf_in;
      sub_ff   <= sub_in;
      swap_ff  <= swap_in;
      prod_ff  <= prod_in;
      if (out_load) begin
         rsp_limb_ff <= (ovf_ff || rtrim_ff == '0) ? '0 : r_q_ff;
         rsp_neg_ff  <= sign_ff && !ovf_ff && (rtrim_ff != '0);
         rsp_ovf_ff  <= ovf_ff;
         rsp_last_ff <= out_last;
      end
   end

   // Operand, column and result stores
   always_ff @(posedge clock) begin
      if (a_we) a_mem[ab_waddr] <= q_cmd.limb;
      if (b_we) b_mem[ab_waddr] <= q_cmd.limb;
      if (p_we) p_mem[p_waddr]  <= p_wdata;
      if (r_we) r_mem[idx_ff]   <= r_wdata;
      a_q_ff <= a_mem[idx_ff];
      b_q_ff <= b_mem[b_raddr];
      p_q_ff <= p_mem[p_raddr];
      r_q_ff <= r_mem[idx_ff];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = sla_pkg::RSP_TDATA_W'(rsp_limb_ff);
   assign rsp_tuser  = {rsp_ovf_ff, rsp_neg_ff};
   assign rsp_tlast  = rsp_last_ff;

   a_ovf_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> rsp_tlast && (rsp_tdata == '0) && !rsp_tuser[0])
      else $error("overflow beat is not a lone zero beat");

   a_trim_a: assert property (@(posedge clock) disable iff (reset)
      a_trim_ff <= a_len_ff)
      else $error("operand A trimmed length exceeds its length");

   a_trim_b: assert property (@(posedge clock) disable iff (reset)
      b_trim_ff <= b_len_ff)
      else $error("operand B trimmed length exceeds its length");

   a_op_starts: assert property (@(posedge clock) disable iff (reset)
      q_pop && (q_cmd.kind == sla_pkg::CMD_ADD || q_cmd.kind == sla_pkg::CMD_SUB ||
                q_cmd.kind == sla_pkg::CMD_MUL)
      |=> (state_ff != ST_IDLE) && (a_len_ff == '0) && (b_len_ff == '0))
      else $error("operation did not start or operands not cleared");

endmodule
`default_nettype wire

### rtl/signed_long_integer_alu.sv
// Top level of the signed multiprecision add, subtract and multiply unit.
//
//  Channel | Dir | Beat contents
//  --------+-----+-----------------------------------------------------------
//  req     | in  | tdata: limb_value[11:0]; tuser: action[2:0], operand_negative[3]
//  rsp     | out | tdata: result_limb[11:0]; tuser: result_negative[0], overflow[1];
//          |     | tlast: last_limb
//
//  Limb appends are handled in the idle state of the back end; a two-entry command queue lets
//  the front take appends on back-to-back cycles while the back end stays idle.
//  Add/subtract: a magnitude compare (equal lengths only) in CMP_RD and CMP_EV per limb,
//  the walk in ADD_RD and ADD_EV per limb, then emission in EM_RD and EM_WT per limb.
//  Multiply: a clear of the product columns, then MUL_RD, MUL_MUL and MUL_WR per limb product
//  through the one shared multiplier and the column store port, a carry fold per column, emission per limb.
//  Reset is synchronous and active high; operands start empty. Operand stores
//  are not cleared. A stalled rsp holds the output register; commands wait in the queue.
`timescale 1ns / 1ps
`default_nettype none
module signed_long_integer_alu #(
   parameter int MAX_LIMBS = sla_pkg::DEFAULT_MAX_LIMBS
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [sla_pkg::REQ_TDATA_W-1:0] req_tdata,  // [11:0] limb_value
   input  wire logic [sla_pkg::REQ_TUSER_W-1:0] req_tuser,  // [2:0] action, [3] operand_negative
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [sla_pkg::RSP_TDATA_W-1:0]      rsp_tdata,  // [11:0] result_limb
   output logic [sla_pkg::RSP_TUSER_W-1:0]      rsp_tuser,  // [0] result_negative, [1] overflow
   output logic                                 rsp_tlast   // last_limb
);

   logic             q_valid;
   logic             q_pop;
   sla_pkg::cmd_type q_cmd;

   // Accept and classify; unused actions are taken and dropped here
   sla_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .action           (req_tuser[2:0]),
      .limb_value       (req_tdata[sla_pkg::LIMB_W-1:0]),
      .operand_negative (req_tuser[3]),
      .q_valid          (q_valid),
      .q_cmd            (q_cmd),
      .q_pop            (q_pop)
   );

   // Hold the operands, run the walks and drive the result beats
   sla_back #(
      .MAX_LIMBS (MAX_LIMBS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
`default_nettype wire
